// ===== sv/rau_pkg.sv =====
`timescale 1ns / 1ps
// package for the rational arithmetic unit: field widths, operation and status codes,
// controller states and the command/status types between controller and datapath

package rau_pkg;

    localparam int FIELD_W        = 32;
    localparam int CMD_W          = 2;
    localparam int RES_DEN_W      = 31;
    localparam int STATUS_W       = 2;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [CMD_W-1:0] OP_ADD = 2'd0;
    localparam logic [CMD_W-1:0] OP_SUB = 2'd1;
    localparam logic [CMD_W-1:0] OP_MUL = 2'd2;
    localparam logic [CMD_W-1:0] OP_DIV = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_Q,
        S_MUL_D,
        S_COMBINE,
        S_GCD,
        S_DIV_N,
        S_DIV_D,
        S_WAIT_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL_P,
        CMD_MUL_Q,
        CMD_MUL_D,
        CMD_COMBINE,
        CMD_GCD_STEP,
        CMD_DIV_N_START,
        CMD_DIV_D_START,
        CMD_DIV_STEP,
        CMD_FINISH
    } dp_cmd_t;

    typedef struct packed {
        logic zero_err;
        logic n_zero;
        logic gcd_done;
        logic div_done;
    } dp_status_t;

endpackage

// ===== sv/rau_dp.sv =====
`timescale 1ns / 1ps
// datapath of the rational arithmetic unit: operand registers, shared multiplier,
// binary gcd, restoring divider and the result registers; uses rau_pkg

module rau_dp
    import rau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    input  logic [CMD_W-1:0]           command,
    input  logic [FIELD_W-1:0]         a_num,
    input  logic [FIELD_W-1:0]         a_den,
    input  logic [FIELD_W-1:0]         b_num,
    input  logic [FIELD_W-1:0]         b_den,
    output dp_status_t                 dp_status,
    output logic signed [FIELD_W-1:0]  res_num,
    output logic [RES_DEN_W-1:0]       res_den,
    output logic [STATUS_W-1:0]        status
);

    localparam int W  = DATA_WIDTH;
    localparam int NW = 2 * DATA_WIDTH;
    localparam int KW = $clog2(NW);
    localparam int CW = $clog2(NW + 1);
    localparam logic [NW-1:0] LIM = {{(NW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [NW-1:0] LIM1 = LIM + NW'(1);

    // operand registers in sign-magnitude form
    logic [CMD_W-1:0] op_reg;
    logic [W-1:0]     an_reg, ad_reg, bn_reg, bd_reg;
    logic             an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;
    logic             zero_err_reg;

    logic [NW-1:0]    p_reg, q_reg, n_reg, d_reg;
    logic             p_neg_reg, q_neg_reg, n_neg_reg, d_neg_reg;

    logic [NW-1:0]    u_reg, v_reg;
    logic [KW-1:0]    k_reg;

    logic [NW-1:0]    g_reg, quo_reg, rem_reg, nm_reg;
    logic [CW-1:0]    cnt_reg;

    logic signed [FIELD_W-1:0] res_num_reg;
    logic [RES_DEN_W-1:0]      res_den_reg;
    logic [STATUS_W-1:0]       status_reg;

    // operand load
    logic [W-1:0] in_an, in_ad, in_bn, in_bd;
    logic [W-1:0] mag_an, mag_ad, mag_bn, mag_bd;

    always_comb
    begin
        in_an  = a_num[W-1:0];
        in_ad  = a_den[W-1:0];
        in_bn  = b_num[W-1:0];
        in_bd  = b_den[W-1:0];
        mag_an = in_an[W-1] ? (~in_an + W'(1)) : in_an;
        mag_ad = in_ad[W-1] ? (~in_ad + W'(1)) : in_ad;
        mag_bn = in_bn[W-1] ? (~in_bn + W'(1)) : in_bn;
        mag_bd = in_bd[W-1] ? (~in_bd + W'(1)) : in_bd;
    end

    // shared multiplier
    logic [W-1:0]  mul_x, mul_y;
    logic          mul_sx, mul_sy;
    logic [NW-1:0] prod;
    logic          prod_neg;

    always_comb
    begin
        mul_x  = an_reg;
        mul_y  = bd_reg;
        mul_sx = an_neg_reg;
        mul_sy = bd_neg_reg;
        case (cmd)
            CMD_MUL_P:
            begin
                mul_x  = an_reg;
                mul_sx = an_neg_reg;
                mul_y  = (op_reg == OP_MUL) ? bn_reg : bd_reg;
                mul_sy = (op_reg == OP_MUL) ? bn_neg_reg : bd_neg_reg;
            end
            CMD_MUL_Q:
            begin
                mul_x  = bn_reg;
                mul_sx = bn_neg_reg ^ (op_reg == OP_SUB);
                mul_y  = ad_reg;
                mul_sy = ad_neg_reg;
            end
            CMD_MUL_D:
            begin
                mul_x  = ad_reg;
                mul_sx = ad_neg_reg;
                mul_y  = (op_reg == OP_DIV) ? bn_reg : bd_reg;
                mul_sy = (op_reg == OP_DIV) ? bn_neg_reg : bd_neg_reg;
            end
            default:
            begin
                mul_x  = an_reg;
                mul_y  = bd_reg;
                mul_sx = an_neg_reg;
                mul_sy = bd_neg_reg;
            end
        endcase
    end

    assign prod     = NW'(mul_x) * NW'(mul_y);
    assign prod_neg = (mul_sx != mul_sy) && (prod != '0);

    // sign-magnitude add of the two cross products
    logic [NW-1:0] sum_mag;
    logic          sum_neg;

    always_comb
    begin
        if ((op_reg == OP_ADD) || (op_reg == OP_SUB))
        begin
            if (p_neg_reg == q_neg_reg)
            begin
                sum_mag = p_reg + q_reg;
                sum_neg = p_neg_reg;
            end
            else if (p_reg >= q_reg)
            begin
                sum_mag = p_reg - q_reg;
                sum_neg = p_neg_reg;
            end
            else
            begin
                sum_mag = q_reg - p_reg;
                sum_neg = q_neg_reg;
            end
            if (sum_mag == '0)
            begin
                sum_neg = 1'b0;
            end
        end
        else
        begin
            sum_mag = p_reg;
            sum_neg = p_neg_reg;
        end
    end

    // binary gcd step and divider step
    logic [NW-1:0] g_comb;
    logic [NW:0]   rem_sh;
    logic          rem_ge;

    assign g_comb = u_reg << k_reg;
    assign rem_sh = {rem_reg, quo_reg[NW-1]};
    assign rem_ge = rem_sh >= {1'b0, g_reg};

    // final scaling and range check
    logic                 res_neg;
    logic                 over;
    logic [W-1:0]         nm_lo;
    logic signed [W-1:0]  num_w;

    always_comb
    begin
        res_neg = n_neg_reg != d_neg_reg;
        over    = (quo_reg > LIM) || (res_neg ? (nm_reg > LIM1) : (nm_reg > LIM));
        nm_lo   = nm_reg[W-1:0];
        num_w   = res_neg ? -nm_lo : nm_lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            case (cmd)
                CMD_DIV_N_START, CMD_DIV_D_START: cnt_reg <= CW'(NW);
                CMD_DIV_STEP:                     cnt_reg <= cnt_reg - CW'(1);
                default:                          cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                op_reg       <= command;
                an_reg       <= mag_an;
                ad_reg       <= mag_ad;
                bn_reg       <= mag_bn;
                bd_reg       <= mag_bd;
                an_neg_reg   <= in_an[W-1];
                ad_neg_reg   <= in_ad[W-1];
                bn_neg_reg   <= in_bn[W-1];
                bd_neg_reg   <= in_bd[W-1];
                zero_err_reg <= (mag_ad == '0) || (mag_bd == '0)
                                || ((command == OP_DIV) && (mag_bn == '0));
            end
            CMD_MUL_P:
            begin
                p_reg     <= prod;
                p_neg_reg <= prod_neg;
            end
            CMD_MUL_Q:
            begin
                q_reg     <= prod;
                q_neg_reg <= prod_neg;
            end
            CMD_MUL_D:
            begin
                d_reg     <= prod;
                d_neg_reg <= prod_neg;
            end
            CMD_COMBINE:
            begin
                n_reg     <= sum_mag;
                n_neg_reg <= sum_neg;
                u_reg     <= sum_mag;
                v_reg     <= d_reg;
                k_reg     <= '0;
            end
            CMD_GCD_STEP:
            begin
                if (!u_reg[0] && !v_reg[0])
                begin
                    u_reg <= u_reg >> 1;
                    v_reg <= v_reg >> 1;
                    k_reg <= k_reg + KW'(1);
                end
                else if (!u_reg[0])
                begin
                    u_reg <= u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_reg <= v_reg >> 1;
                end
                else if (u_reg > v_reg)
                begin
                    u_reg <= (u_reg - v_reg) >> 1;
                end
                else
                begin
                    v_reg <= (v_reg - u_reg) >> 1;
                end
            end
            CMD_DIV_N_START:
            begin
                g_reg   <= g_comb;
                quo_reg <= n_reg;
                rem_reg <= '0;
            end
            CMD_DIV_D_START:
            begin
                nm_reg  <= quo_reg;
                quo_reg <= d_reg;
                rem_reg <= '0;
            end
            CMD_DIV_STEP:
            begin
                if (rem_ge)
                begin
                    rem_reg <= NW'(rem_sh - {1'b0, g_reg});
                    quo_reg <= {quo_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[NW-1:0];
                    quo_reg <= {quo_reg[NW-2:0], 1'b0};
                end
            end
            CMD_FINISH:
            begin
                if (zero_err_reg)
                begin
                    res_num_reg <= '0;
                    res_den_reg <= '0;
                    status_reg  <= ST_ZERO_DEN;
                end
                else if (n_reg == '0)
                begin
                    res_num_reg <= '0;
                    res_den_reg <= RES_DEN_W'(1);
                    status_reg  <= ST_OK;
                end
                else if (over)
                begin
                    res_num_reg <= '0;
                    res_den_reg <= '0;
                    status_reg  <= ST_OVERFLOW;
                end
                else
                begin
                    res_num_reg <= FIELD_W'(num_w);
                    res_den_reg <= RES_DEN_W'(quo_reg[W-2:0]);
                    status_reg  <= ST_OK;
                end
            end
            default:
            begin
                op_reg <= op_reg;
            end
        endcase
    end

    assign dp_status.zero_err = zero_err_reg;
    assign dp_status.n_zero   = (n_reg == '0);
    assign dp_status.gcd_done = (u_reg == v_reg);
    assign dp_status.div_done = (cnt_reg == '0);

    assign res_num = res_num_reg;
    assign res_den = res_den_reg;
    assign status  = status_reg;

    // a reduced result that passes the range check has a nonzero denominator
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_FINISH) |=> (status_reg != ST_OK) || (res_den_reg != '0))
        else $error("ok result with zero denominator");

    // gcd iteration only ever runs on two nonzero values
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_GCD_STEP) |-> (u_reg != '0) && (v_reg != '0))
        else $error("gcd step on zero operand");

    // divider count stays within one full pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= CW'(NW)))
        else $error("divider count out of range");

endmodule

// ===== sv/rau_ctrl.sv =====
`timescale 1ns / 1ps
// controller of the rational arithmetic unit: sequences load, products, gcd,
// divisions and the output register handshake; uses rau_pkg

module rau_ctrl
    import rau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t dp_status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = CMD_NONE;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_MUL_P;
                end
            end
            S_MUL_P:
            begin
                if (dp_status.zero_err)
                begin
                    state_next = S_WAIT_OUT;
                end
                else
                begin
                    cmd        = CMD_MUL_P;
                    state_next = S_MUL_Q;
                end
            end
            S_MUL_Q:
            begin
                cmd        = CMD_MUL_Q;
                state_next = S_MUL_D;
            end
            S_MUL_D:
            begin
                cmd        = CMD_MUL_D;
                state_next = S_COMBINE;
            end
            S_COMBINE:
            begin
                cmd        = CMD_COMBINE;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                if (dp_status.n_zero)
                begin
                    state_next = S_WAIT_OUT;
                end
                else if (dp_status.gcd_done)
                begin
                    cmd        = CMD_DIV_N_START;
                    state_next = S_DIV_N;
                end
                else
                begin
                    cmd = CMD_GCD_STEP;
                end
            end
            S_DIV_N:
            begin
                if (dp_status.div_done)
                begin
                    cmd        = CMD_DIV_D_START;
                    state_next = S_DIV_D;
                end
                else
                begin
                    cmd = CMD_DIV_STEP;
                end
            end
            S_DIV_D:
            begin
                if (dp_status.div_done)
                begin
                    state_next = S_WAIT_OUT;
                end
                else
                begin
                    cmd = CMD_DIV_STEP;
                end
            end
            S_WAIT_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd            = CMD_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // an accepted item always starts with the product phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_MUL_P))
        else $error("accepted item did not start products");

    // a result appears only out of the output wait state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_WAIT_OUT))
        else $error("result raised outside output wait");

    // gcd is entered only from the combine step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GCD) |-> ($past(state_reg) == S_COMBINE)
                                 || ($past(state_reg) == S_GCD))
        else $error("gcd entered out of sequence");

endmodule

// ===== sv/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Rational arithmetic unit. Takes a command (add, subtract, multiply, divide) and two
// signed fractions, forms the products at double width in sign-magnitude form,
// reduces numerator and denominator by their gcd and returns the reduced fraction with the
// sign on the numerator and a status (ok, zero denominator, overflow; result fields are
// zero on error). Only the low DATA_WIDTH bits of each operand are used. One item is in
// work at a time: three products on the shared multiplier, a combine step, a binary gcd
// with one shift or subtract-and-shift per cycle, then two restoring divisions of
// 2*DATA_WIDTH quotient bits each; a zero denominator skips the products and a zero
// numerator skips the gcd and divisions. The result sits in an output register, so a new
// item is taken while it waits for transfer.
// Depends on rau_pkg, rau_ctrl and rau_dp.

module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // input transfer
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [CMD_W-1:0]           command,
    input  logic [FIELD_W-1:0]         a_num,
    input  logic [FIELD_W-1:0]         a_den,
    input  logic [FIELD_W-1:0]         b_num,
    input  logic [FIELD_W-1:0]         b_den,
    // result transfer
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [FIELD_W-1:0]  res_num,
    output logic [RES_DEN_W-1:0]       res_den,
    output logic [STATUS_W-1:0]        status
);

    // command and status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t dp_status;

    // sequencer: owns the handshakes and steps the datapath
    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // datapath: products, gcd, divisions and the result register
    rau_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .command   (command),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .dp_status (dp_status),
        .res_num   (res_num),
        .res_den   (res_den),
        .status    (status)
    );

endmodule

// ===== sim/rau_checker.sv =====
`timescale 1ns / 1ps
// result checker for the rational arithmetic unit: watches both transfers, predicts each
// reduced fraction and compares it with the block's result; depends on rau_pkg

module rau_checker
    import rau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [CMD_W-1:0]          command,
    input  logic [FIELD_W-1:0]        a_num,
    input  logic [FIELD_W-1:0]        a_den,
    input  logic [FIELD_W-1:0]        b_num,
    input  logic [FIELD_W-1:0]        b_den,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic signed [FIELD_W-1:0] res_num,
    input  logic [RES_DEN_W-1:0]      res_den,
    input  logic [STATUS_W-1:0]       status,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic [FIELD_W-1:0]   num;
        logic [RES_DEN_W-1:0] den;
        logic [STATUS_W-1:0]  st;
    } fraction_t;

    typedef struct {
        bit        neg;
        bit [63:0] mag;
    } smag_t;

    fraction_t fractions_due[$];

    function automatic smag_t to_smag(logic [FIELD_W-1:0] raw);
        smag_t r;
        bit [63:0] v;
        v = 64'(raw) & ((64'd1 << DATA_WIDTH) - 1);
        r.neg = v[DATA_WIDTH-1];
        r.mag = r.neg ? (64'd1 << DATA_WIDTH) - v : v;
        return r;
    endfunction

    function automatic smag_t smul(smag_t x, smag_t y);
        smag_t r;
        r.mag = x.mag * y.mag;
        r.neg = (x.neg != y.neg) && r.mag != 0;
        return r;
    endfunction

    function automatic smag_t sadd(smag_t x, smag_t y);
        smag_t r;
        if (x.neg == y.neg)
        begin
            r.mag = x.mag + y.mag;
            r.neg = x.neg;
        end
        else if (x.mag >= y.mag)
        begin
            r.mag = x.mag - y.mag;
            r.neg = x.neg;
        end
        else
        begin
            r.mag = y.mag - x.mag;
            r.neg = y.neg;
        end
        if (r.mag == 0)
            r.neg = 0;
        return r;
    endfunction

    function automatic fraction_t reduce_fraction(logic [CMD_W-1:0] op, logic [FIELD_W-1:0] an_r,
                                                  logic [FIELD_W-1:0] ad_r,
                                                  logic [FIELD_W-1:0] bn_r,
                                                  logic [FIELD_W-1:0] bd_r);
        fraction_t f;
        smag_t an, ad, bn, bd, n, d;
        bit [63:0] x, y, t, nm, dm, lim;
        bit neg;
        an = to_smag(an_r);
        ad = to_smag(ad_r);
        bn = to_smag(bn_r);
        bd = to_smag(bd_r);
        f = '0;
        if (op == OP_SUB)
            bn.neg = !bn.neg && bn.mag != 0;
        case (op)
            OP_ADD, OP_SUB:
            begin
                n = sadd(smul(an, bd), smul(bn, ad));
                d = smul(ad, bd);
            end
            OP_MUL:
            begin
                n = smul(an, bn);
                d = smul(ad, bd);
            end
            default:
            begin
                n = smul(an, bd);
                d = smul(ad, bn);
            end
        endcase
        if (ad.mag == 0 || bd.mag == 0 || d.mag == 0)
        begin
            f.st = ST_ZERO_DEN;
            return f;
        end
        x = n.mag;
        y = d.mag;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        nm = n.mag / x;
        dm = d.mag / x;
        neg = (n.neg != d.neg) && nm != 0;
        lim = (64'd1 << (DATA_WIDTH - 1)) - 1;
        if (dm > lim || (neg ? nm > lim + 1 : nm > lim))
        begin
            f.st = ST_OVERFLOW;
            return f;
        end
        f.num = neg ? FIELD_W'(64'd0 - nm) : FIELD_W'(nm);
        f.den = RES_DEN_W'(dm);
        f.st = ST_OK;
        return f;
    endfunction

    assign pending = fractions_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        fraction_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                fractions_due.push_back(reduce_fraction(command, a_num, a_den, b_num, b_den));
            if (out_valid && out_ready)
            begin
                if (fractions_due.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = fractions_due.pop_front();
                    if (res_num !== want.num || res_den !== want.den || status !== want.st)
                    begin
                        if (res_num !== want.num)
                            $error("res_num expected %0d actual %0d",
                                   $signed(want.num), res_num);
                        if (res_den !== want.den)
                            $error("res_den expected %0d actual %0d", want.den, res_den);
                        if (status !== want.st)
                            $error("status expected %0d actual %0d", want.st, status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top for the rational arithmetic unit: drives bursty operand transfers and a
// stalling result side, gives the verdict; depends on rau_pkg, the block and rau_checker

module tb_top;
    import rau_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [CMD_W-1:0]          command;
    logic [FIELD_W-1:0]        a_num;
    logic [FIELD_W-1:0]        a_den;
    logic [FIELD_W-1:0]        b_num;
    logic [FIELD_W-1:0]        b_den;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [FIELD_W-1:0] res_num;
    logic [RES_DEN_W-1:0]      res_den;
    logic [STATUS_W-1:0]       status;
    int                        fail_count;
    int                        pending;

    rational_arithmetic_unit DUT (.*);

    rau_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // hard stop: 1420 items plus result-side stalls stay well below this
    initial
    begin
        #200ms;
        $display("FAILED: results differ");
        $finish;
    end

    // result side stalls: modes alternate between always ready, random and long stalls
    initial
    begin
        int mode;
        out_ready <= 0;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(50, 2000))
            begin
                @(posedge clk);
                case (mode)
                    0: out_ready <= 1;
                    1: out_ready <= $urandom_range(0, 1);
                    default: out_ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    // operand with a bias toward the values that hit sign and range corners
    function automatic logic [FIELD_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return 32'd1;
            5: return FIELD_W'($signed($urandom_range(0, 40)) - 20);
            6: return FIELD_W'($urandom_range(0, 4095)) * ($urandom_range(0, 1) ? 1 : -1);
            default: return $urandom;
        endcase
    endfunction

    // one operand transfer; valid is held until accepted
    task automatic send_item(logic [CMD_W-1:0] op, logic [FIELD_W-1:0] an,
                             logic [FIELD_W-1:0] ad, logic [FIELD_W-1:0] bn,
                             logic [FIELD_W-1:0] bd);
        in_valid <= 1;
        command  <= op;
        a_num    <= an;
        a_den    <= ad;
        b_num    <= bn;
        b_den    <= bd;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drop_valid();
        in_valid <= 0;
    endtask

    initial
    begin
        logic [CMD_W-1:0] op;
        int               burst;
        int               left;
        in_valid <= 0;
        command  <= OP_ADD;
        a_num    <= 0;
        a_den    <= 1;
        b_num    <= 0;
        b_den    <= 1;
        rst_n    <= 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: each operation, zero denominators, zero numerator, extremes, overflow
        send_item(OP_ADD, 1, 2, 1, 3);
        send_item(OP_SUB, 1, 2, 1, 3);
        send_item(OP_MUL, -2, 3, 3, 4);
        send_item(OP_DIV, 3, -4, 9, 8);
        send_item(OP_ADD, 1, 0, 1, 3);
        send_item(OP_SUB, 1, 3, 1, 0);
        send_item(OP_DIV, 5, 7, 0, 3);
        send_item(OP_MUL, 0, 7, 5, 3);
        send_item(OP_SUB, 2, 6, 1, 3);
        send_item(OP_MUL, 32'h8000_0000, 1, 32'hffff_ffff, 1);
        send_item(OP_DIV, 32'h8000_0000, 1, 32'hffff_ffff, 1);
        send_item(OP_MUL, 32'h8000_0000, 1, 1, 1);
        send_item(OP_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
        send_item(OP_SUB, 32'h8000_0000, 1, 1, 1);
        send_item(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_item(OP_MUL, 1, 32'h8000_0000, 1, 32'hffff_ffff);
        send_item(OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_item(OP_MUL, 32'h7fff_fffe, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_fffe);
        send_item(OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_item(OP_DIV, 32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 32'hf0f0_f0f0);
        drop_valid();

        // hold off until everything sent so far has come back; one edge first so the
        // last transfer is already counted
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        left = 1400;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0)
            begin
                op = CMD_W'($urandom_range(0, 3));
                send_item(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                drop_valid();
                repeat ($urandom_range(1, 400)) @(posedge clk);
            end
        end
        drop_valid();

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
        if (pending == 0 && fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
